FILE: rtl/core/slls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slls_pkg
// Shared types, constants and helpers of the sorted line LCP statistics block.
// ----------------------------------------------------------------------------
package slls_pkg;

	localparam int MAX_LINE = 4096;
	localparam int ADDR_W   = $clog2(MAX_LINE);
	localparam int LEN_W    = 13;
	localparam int SYM_W    = 8;
	localparam int TOT_W    = 48;

	localparam logic [TOT_W-1:0] SAT_MAX  = {TOT_W{1'b1}};
	localparam logic [TOT_W-1:0] LINE_MAX = TOT_W'(MAX_LINE);

	typedef enum logic {
		OP_CHAR = 1'b0,
		OP_EOL  = 1'b1
	} op_t;

	function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
	                                             input logic [TOT_W-1:0] b);
		logic [TOT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TOT_W] ? SAT_MAX : s[TOT_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/slls_char_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slls_char_if
// Input channel: one character or end of line per word.
// ----------------------------------------------------------------------------
interface slls_char_if;
	logic                          valid;
	logic                          ready;
	slls_pkg::op_t                 op;
	logic [slls_pkg::SYM_W-1:0]    symbol;

	modport source (output valid, output op, output symbol, input ready);
	modport sink   (input valid, input op, input symbol, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/slls_stat_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slls_stat_if
// Output channel: per-line prefix result and running totals.
// ----------------------------------------------------------------------------
interface slls_stat_if;
	logic                          valid;
	logic                          ready;
	logic [slls_pkg::LEN_W-1:0]    line_lcp;
	logic [slls_pkg::TOT_W-1:0]    lines_seen;
	logic [slls_pkg::TOT_W-1:0]    chars_seen;
	logic [slls_pkg::TOT_W-1:0]    lcp_sum;
	logic [slls_pkg::TOT_W-1:0]    dprefix_sum;
	logic                          order_error;
	logic                          overlong;

	modport source (output valid, output line_lcp, output lines_seen, output chars_seen,
	                output lcp_sum, output dprefix_sum, output order_error,
	                output overlong, input ready);
	modport sink   (input valid, input line_lcp, input lines_seen, input chars_seen,
	                input lcp_sum, input dprefix_sum, input order_error,
	                input overlong, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/slls_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slls_ram
// Generic single-clock RAM, one write and one read port, registered read,
// read-first on a same-address write.
// ----------------------------------------------------------------------------
module slls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/sorted_line_lcp_stats.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_line_lcp_stats
// Longest common prefix of each line with the previous one, order check and
// saturating line, character, LCP and distinguishing-prefix totals.
// ----------------------------------------------------------------------------
// One word per cycle, characters and ends of line alike; an end of line passes
// the compare stage and result registers. Each character reads, and below
// position 4096 rewrites, its position of the previous-line store (4096 x 8,
// one read and one write port) when taken; the stored byte is compared next cycle.
// The input stalls only while an end of line waits behind an untaken result.
// Characters past 4096 are counted but not compared and mark the line overlong.
// After a line sorts below its predecessor, order_error stays set and the
// totals hold; per-line LCP and overlong are still reported.
module sorted_line_lcp_stats (
	input  wire logic   clk,
	input  wire logic   arst_n,
	slls_char_if.sink   chars,
	slls_stat_if.source stats
);

	localparam int AW = slls_pkg::ADDR_W;
	localparam int LW = slls_pkg::LEN_W;
	localparam int SW = slls_pkg::SYM_W;
	localparam int TW = slls_pkg::TOT_W;

	// input stage
	logic [TW-1:0] pos_q;
	logic          in_fire;
	logic          in_char;
	logic          stall_s1;

	// compare stage
	logic          vld_s1;
	slls_pkg::op_t op_s1;
	logic [SW-1:0] sym_s1;
	logic [TW-1:0] pos_s1;
	logic [SW-1:0] old_sym;
	logic          fire_s1;

	// per-line and total state
	logic [LW-1:0] prev_len_q;
	logic [LW-1:0] match_depth_q;
	logic          matching_q;
	logic [LW-1:0] prev_dist_q;
	logic [TW-1:0] line_total_q;
	logic [TW-1:0] char_total_q;
	logic [TW-1:0] lcp_total_q;
	logic [TW-1:0] dp_total_q;
	logic          err_q;
	logic          overlong_q;

	// end of line math
	logic [LW-1:0] stored_len;
	logic          eol_err;
	logic [LW-1:0] dist_len;
	logic [LW-1:0] dist_gain;
	logic [LW:0]   dp_inc;

	// result register
	logic          out_vld_q;
	logic [LW-1:0] out_lcp_q;
	logic [TW-1:0] out_lines_q;
	logic [TW-1:0] out_chars_q;
	logic [TW-1:0] out_lcp_sum_q;
	logic [TW-1:0] out_dp_q;
	logic          out_err_q;
	logic          out_ovl_q;

	assign stall_s1    = vld_s1 && (op_s1 == slls_pkg::OP_EOL) && out_vld_q && !stats.ready;
	assign chars.ready = !stall_s1;
	assign in_fire     = chars.valid && chars.ready;
	assign in_char     = in_fire && (chars.op == slls_pkg::OP_CHAR);
	assign fire_s1     = vld_s1 && !stall_s1;

	slls_ram #(
		.WIDTH (SW),
		.DEPTH (slls_pkg::MAX_LINE)
	) u_line_store (
		.clk   (clk),
		.we    (in_char && (pos_q < slls_pkg::LINE_MAX)),
		.waddr (pos_q[AW-1:0]),
		.wdata (chars.symbol),
		.re    (in_char),
		.raddr (pos_q[AW-1:0]),
		.rdata (old_sym)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_fire) begin
			if (chars.op == slls_pkg::OP_EOL) begin
				pos_q <= '0;
			end else if (pos_q != slls_pkg::SAT_MAX) begin
				pos_q <= pos_q + TW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!stall_s1) begin
			vld_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1  <= chars.op;
			sym_s1 <= chars.symbol;
			pos_s1 <= pos_q;
		end
	end

	always_comb begin
		stored_len = (pos_s1 < slls_pkg::LINE_MAX) ? pos_s1[LW-1:0] : LW'(slls_pkg::MAX_LINE);
		eol_err    = err_q || (matching_q && (stored_len < prev_len_q));
		dist_len   = match_depth_q + LW'(1);
		dist_gain  = (prev_dist_q < dist_len) ? (dist_len - prev_dist_q) : '0;
		dp_inc     = {1'b0, dist_gain} + {1'b0, dist_len};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_len_q    <= '0;
			match_depth_q <= '0;
			matching_q    <= 1'b1;
			prev_dist_q   <= '0;
			line_total_q  <= '0;
			char_total_q  <= '0;
			lcp_total_q   <= '0;
			dp_total_q    <= '0;
			err_q         <= 1'b0;
			overlong_q    <= 1'b0;
		end else if (fire_s1) begin
			if (op_s1 == slls_pkg::OP_CHAR) begin
				if (pos_s1 < slls_pkg::LINE_MAX) begin
					if (matching_q) begin
						if (pos_s1 < TW'(prev_len_q)) begin
							if (old_sym == sym_s1) begin
								match_depth_q <= match_depth_q + LW'(1);
							end else begin
								matching_q <= 1'b0;
								if (sym_s1 < old_sym) begin
									err_q <= 1'b1;
								end
							end
						end else begin
							matching_q <= 1'b0;
						end
					end
				end else begin
					overlong_q <= 1'b1;
				end
			end else begin
				err_q <= eol_err;
				if (!eol_err) begin
					prev_dist_q  <= dist_len;
					dp_total_q   <= slls_pkg::sat_add(dp_total_q, TW'(dp_inc));
					lcp_total_q  <= slls_pkg::sat_add(lcp_total_q, TW'(match_depth_q));
					line_total_q <= slls_pkg::sat_add(line_total_q, TW'(1));
					char_total_q <= slls_pkg::sat_add(char_total_q, pos_s1);
				end
				prev_len_q    <= stored_len;
				match_depth_q <= '0;
				matching_q    <= 1'b1;
				overlong_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire_s1 && (op_s1 == slls_pkg::OP_EOL)) begin
			out_vld_q <= 1'b1;
		end else if (stats.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// totals after this line's update
	always_ff @(posedge clk) begin
		if (fire_s1 && (op_s1 == slls_pkg::OP_EOL)) begin
			out_lcp_q     <= match_depth_q;
			out_err_q     <= eol_err;
			out_ovl_q     <= overlong_q;
			out_lines_q   <= eol_err ? line_total_q
			                         : slls_pkg::sat_add(line_total_q, TW'(1));
			out_chars_q   <= eol_err ? char_total_q
			                         : slls_pkg::sat_add(char_total_q, pos_s1);
			out_lcp_sum_q <= eol_err ? lcp_total_q
			                         : slls_pkg::sat_add(lcp_total_q, TW'(match_depth_q));
			out_dp_q      <= eol_err ? dp_total_q
			                         : slls_pkg::sat_add(dp_total_q, TW'(dp_inc));
		end
	end

	assign stats.valid       = out_vld_q;
	assign stats.line_lcp    = out_lcp_q;
	assign stats.lines_seen  = out_lines_q;
	assign stats.chars_seen  = out_chars_q;
	assign stats.lcp_sum     = out_lcp_sum_q;
	assign stats.dprefix_sum = out_dp_q;
	assign stats.order_error = out_err_q;
	assign stats.overlong    = out_ovl_q;

	a_err_sticky : assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("order error cleared");

	a_totals_frozen : assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> ($stable(line_total_q) && $stable(char_total_q) &&
		           $stable(lcp_total_q) && $stable(dp_total_q)))
		else $error("totals moved after order error");

	a_depth_bound : assert property (@(posedge clk) disable iff (!arst_n)
		match_depth_q <= prev_len_q)
		else $error("match depth beyond previous line length");

	a_stall_cause : assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> (out_vld_q && vld_s1 && (op_s1 == slls_pkg::OP_EOL)))
		else $error("input stalled without pending result");

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks sorted_line_lcp_stats against a cycle-free predictor of per-line
// prefix length, order check and saturating totals. Directed, overlong,
// random sorted, backpressure and out-of-order line streams are sent through
// valid/ready channels with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

	localparam int QUIET_LIMIT = 20000;
	localparam int PRINT_LIMIT = 40;

	typedef logic [slls_pkg::SYM_W-1:0] text_line_t [$];

	typedef struct packed {
		logic [slls_pkg::LEN_W-1:0] lcp;
		logic [slls_pkg::TOT_W-1:0] lines;
		logic [slls_pkg::TOT_W-1:0] chars;
		logic [slls_pkg::TOT_W-1:0] lcps;
		logic [slls_pkg::TOT_W-1:0] dprefix;
		logic                       order_error;
		logic                       overlong;
	} line_stats_t;

	logic clk;
	logic arst_n = 1'b0;

	slls_char_if chars_if ();
	slls_stat_if stats_if ();

	sorted_line_lcp_stats dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.stats  (stats_if)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// shadow of the block state
	logic [slls_pkg::SYM_W-1:0] shadow_line [slls_pkg::MAX_LINE];
	logic [slls_pkg::LEN_W-1:0] shadow_len   = '0;
	logic [slls_pkg::TOT_W-1:0] cur_pos      = '0;
	logic [slls_pkg::LEN_W-1:0] cur_match    = '0;
	logic                       still_equal  = 1'b1;
	logic [slls_pkg::LEN_W-1:0] last_dprefix = '0;
	logic [slls_pkg::TOT_W-1:0] tot_lines    = '0;
	logic [slls_pkg::TOT_W-1:0] tot_chars    = '0;
	logic [slls_pkg::TOT_W-1:0] tot_lcp      = '0;
	logic [slls_pkg::TOT_W-1:0] tot_dprefix  = '0;
	logic                       order_bad    = 1'b0;
	logic                       line_long    = 1'b0;

	line_stats_t expected_line_stats [$];
	text_line_t  gen_prev;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles   = 0;
	int words_sent    = 0;
	int results_seen  = 0;
	int long_lines    = 0;
	int frozen_lines  = 0;
	int mismatches    = 0;
	int quiet_cycles  = 0;

	function automatic logic [slls_pkg::TOT_W-1:0] add_sat48(logic [slls_pkg::TOT_W-1:0] a,
	                                                          logic [slls_pkg::TOT_W-1:0] b);
		return (a > slls_pkg::SAT_MAX - b) ? slls_pkg::SAT_MAX : a + b;
	endfunction

	task automatic advance_prefix_state(slls_pkg::op_t op, logic [slls_pkg::SYM_W-1:0] sym);
		logic [slls_pkg::LEN_W-1:0] stored;
		logic [slls_pkg::TOT_W-1:0] dprefix_step;
		line_stats_t                want;
		if (op == slls_pkg::OP_CHAR) begin
			if (cur_pos < slls_pkg::MAX_LINE) begin
				if (still_equal) begin
					if (cur_pos < shadow_len) begin
						if (shadow_line[cur_pos[slls_pkg::ADDR_W-1:0]] == sym) begin
							cur_match++;
						end else begin
							still_equal = 1'b0;
							if (sym < shadow_line[cur_pos[slls_pkg::ADDR_W-1:0]])
								order_bad = 1'b1;
						end
					end else begin
						still_equal = 1'b0;
					end
				end
				shadow_line[cur_pos[slls_pkg::ADDR_W-1:0]] = sym;
			end else begin
				line_long = 1'b1;
			end
			if (cur_pos != slls_pkg::SAT_MAX) cur_pos++;
		end else begin
			stored = (cur_pos < slls_pkg::MAX_LINE) ? cur_pos[slls_pkg::LEN_W-1:0]
			                                        : slls_pkg::LEN_W'(slls_pkg::MAX_LINE);
			if (still_equal && stored < shadow_len) order_bad = 1'b1;
			if (!order_bad) begin
				dprefix_step = slls_pkg::TOT_W'(cur_match) + slls_pkg::TOT_W'(1);
				if (slls_pkg::TOT_W'(last_dprefix) < dprefix_step)
					tot_dprefix = add_sat48(tot_dprefix,
					                        dprefix_step - slls_pkg::TOT_W'(last_dprefix));
				tot_dprefix  = add_sat48(tot_dprefix, dprefix_step);
				last_dprefix = dprefix_step[slls_pkg::LEN_W-1:0];
				tot_lcp      = add_sat48(tot_lcp, slls_pkg::TOT_W'(cur_match));
				tot_lines    = add_sat48(tot_lines, slls_pkg::TOT_W'(1));
				tot_chars    = add_sat48(tot_chars, cur_pos);
			end
			want.lcp         = cur_match;
			want.lines       = tot_lines;
			want.chars       = tot_chars;
			want.lcps        = tot_lcp;
			want.dprefix     = tot_dprefix;
			want.order_error = order_bad;
			want.overlong    = line_long;
			expected_line_stats.push_back(want);
			shadow_len  = stored;
			cur_pos     = '0;
			cur_match   = '0;
			still_equal = 1'b1;
			line_long   = 1'b0;
		end
	endtask

	task automatic report_mismatch(string field, logic [slls_pkg::TOT_W-1:0] got,
	                               logic [slls_pkg::TOT_W-1:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, field, got, want);
		mismatches++;
	endtask

	task automatic check_result();
		line_stats_t want;
		if (expected_line_stats.size() == 0) begin
			report_mismatch("result with nothing expected", stats_if.lines_seen, '0);
		end else begin
			want = expected_line_stats.pop_front();
			if (stats_if.line_lcp !== want.lcp)
				report_mismatch("line_lcp", slls_pkg::TOT_W'(stats_if.line_lcp),
				                slls_pkg::TOT_W'(want.lcp));
			if (stats_if.lines_seen !== want.lines)
				report_mismatch("lines_seen", stats_if.lines_seen, want.lines);
			if (stats_if.chars_seen !== want.chars)
				report_mismatch("chars_seen", stats_if.chars_seen, want.chars);
			if (stats_if.lcp_sum !== want.lcps)
				report_mismatch("lcp_sum", stats_if.lcp_sum, want.lcps);
			if (stats_if.dprefix_sum !== want.dprefix)
				report_mismatch("dprefix_sum", stats_if.dprefix_sum, want.dprefix);
			if (stats_if.order_error !== want.order_error)
				report_mismatch("order_error", slls_pkg::TOT_W'(stats_if.order_error),
				                slls_pkg::TOT_W'(want.order_error));
			if (stats_if.overlong !== want.overlong)
				report_mismatch("overlong", slls_pkg::TOT_W'(stats_if.overlong),
				                slls_pkg::TOT_W'(want.overlong));
			if (want.overlong) long_lines++;
			if (want.order_error) frozen_lines++;
		end
		results_seen++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (chars_if.valid && chars_if.ready)
				advance_prefix_state(chars_if.op, chars_if.symbol);
			if (stats_if.valid && stats_if.ready)
				check_result();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((chars_if.valid && chars_if.ready) || (stats_if.valid && stats_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// result side: long hold when requested, else random stalls
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			stats_if.ready <= 1'b0;
		end else begin
			stats_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic send_word(slls_pkg::op_t op, logic [slls_pkg::SYM_W-1:0] sym);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(negedge clk);
		end
		chars_if.valid  <= 1'b1;
		chars_if.op     <= op;
		chars_if.symbol <= sym;
		do @(posedge clk); while (!chars_if.ready);
		words_sent++;
	endtask

	task automatic send_line(text_line_t l);
		foreach (l[i]) send_word(slls_pkg::OP_CHAR, l[i]);
		// symbol is a don't-care on end of line
		send_word(slls_pkg::OP_EOL, slls_pkg::SYM_W'($urandom_range(0, 255)));
		gen_prev = l;
	endtask

	function automatic logic [slls_pkg::SYM_W-1:0] random_symbol();
		if ($urandom_range(0, 3) == 0) return slls_pkg::SYM_W'($urandom_range(1, 255));
		return slls_pkg::SYM_W'($urandom_range(97, 101));
	endfunction

	// next line sorts at or above gen_prev
	task automatic make_sorted_line(output text_line_t l);
		int plen, k, lo, hi, tail;
		plen = gen_prev.size();
		if (plen > 24)
			k = $urandom_range(0, 12);
		else if ($urandom_range(0, 3) != 0)
			k = plen - int'($urandom_range(0, (plen < 2) ? plen : 2));
		else
			k = $urandom_range(0, plen);
		while (k < plen && gen_prev[k] == 8'hff) k++;
		l = {};
		for (int i = 0; i < k; i++) l.push_back(gen_prev[i]);
		if (k < plen) begin
			lo = gen_prev[k] + 1;
			hi = (k == 0 || lo > 253) ? lo : lo + 2;
			l.push_back(slls_pkg::SYM_W'($urandom_range(lo, hi)));
		end
		tail = $urandom_range(0, 4);
		repeat (tail) l.push_back(random_symbol());
	endtask

	task automatic run_sorted_lines(int words);
		text_line_t l;
		int         target;
		target = words_sent + words;
		while (words_sent < target) begin
			make_sorted_line(l);
			send_line(l);
		end
	endtask

	task automatic test_directed();
		text_line_t l;
		l = {};                         send_line(l);  // empty first line
		l = {8'h00};                    send_line(l);  // zero byte
		l = {8'h00, 8'h01};             send_line(l);
		l = {8'h00, 8'h01};             send_line(l);  // equal line
		l = {8'h00, 8'h01, 8'hff};      send_line(l);
		l = {8'h01};                    send_line(l);
		l = {8'h01, 8'h80, 8'h7f};      send_line(l);
		l = {8'h55, 8'haa};             send_line(l);
	endtask

	// one line just past the store length
	task automatic test_overlong();
		text_line_t l;
		l = gen_prev;
		while (l.size() < slls_pkg::MAX_LINE + 2) l.push_back(random_symbol());
		send_line(l);
	endtask

	task automatic test_random_mix(int s_pct, int r_pct, int words);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		run_sorted_lines(words);
	endtask

	task automatic test_backpressure();
		text_line_t l;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles   = 600;
		repeat (40) begin
			make_sorted_line(l);
			send_line(l);
		end
	endtask

	task automatic test_order_error();
		text_line_t l;
		int         target, len;
		l = gen_prev;
		l.push_back(8'h6d);
		send_line(l);
		l[l.size()-1] = 8'h6c;              // lower byte at the first difference
		send_line(l);
		l.delete(l.size() - 1);             // proper prefix of the previous line
		send_line(l);
		target = words_sent + 300;
		while (words_sent < target) begin
			case ($urandom_range(0, 2))
				0: make_sorted_line(l);
				1: begin
					l = gen_prev;
					if (l.size() > 0) l.delete(l.size() - 1);
				end
				default: begin
					l = {};
					len = $urandom_range(0, 6);
					repeat (len) l.push_back(slls_pkg::SYM_W'($urandom_range(0, 255)));
				end
			endcase
			send_line(l);
		end
	endtask

	initial begin
		chars_if.valid  = 1'b0;
		chars_if.op     = slls_pkg::OP_CHAR;
		chars_if.symbol = '0;
		stats_if.ready  = 1'b0;
		gen_prev        = {};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_overlong();
		test_random_mix(7, 79, 550);
		test_random_mix(79, 7, 550);
		test_random_mix(0, 0, 550);
		test_backpressure();
		test_order_error();

		@(negedge clk);
		chars_if.valid <= 1'b0;
		while (expected_line_stats.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("run: %0d words sent, %0d line results checked, %0d overlong lines",
		         words_sent, results_seen, long_lines);
		$display("run: %0d lines checked with the order error set and totals frozen",
		         frozen_lines);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/slls_pkg.sv
rtl/core/slls_char_if.sv
rtl/core/slls_stat_if.sv
rtl/core/slls_ram.sv
rtl/core/sorted_line_lcp_stats.sv
dv/testbench.sv
